>>> src/srsu_pkg.sv
// shared types, codes and constants for the sparse row scatter update unit
`timescale 1ns / 1ps

package srsu_pkg;

  // element width and packed stream widths
  localparam int DW    = 32;
  localparam int IN_W  = 48;
  localparam int OUT_W = 40;

  // default table geometry
  localparam int DEF_MAX_ROWS  = 256;
  localparam int DEF_MAX_WIDTH = 64;

  // item kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_APPLY = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // scatter operations
  localparam logic [2:0] OP_ASSIGN = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_SUB    = 3'd2;
  localparam logic [2:0] OP_RSUB   = 3'd3;
  localparam logic [2:0] OP_MUL    = 3'd4;
  localparam logic [2:0] OP_DIV    = 3'd5;
  localparam logic [2:0] OP_RDIV   = 3'd6;

  // result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RANGE = 2'd1;
  localparam logic [1:0] STS_DIVZ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_OP     = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // configuration reset values
  localparam logic [2:0] RST_OP     = OP_ADD;
  localparam logic [6:0] RST_WIDTH  = 7'd64;
  localparam logic [8:0] RST_HEIGHT = 9'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic exec;
    logic div_start;
    logic div_load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> src/srsu_div.sv
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps

module srsu_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [srsu_pkg::DW-1:0] dividend,
  input  logic [srsu_pkg::DW-1:0] divisor,
  output logic                   done,
  output logic [srsu_pkg::DW-1:0] quotient
);
  import srsu_pkg::*;

  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] quo;
  logic [DW-1:0] dvs;
  logic          neg;
  logic [DW:0]   trial;

  assign trial    = {rem, quo[DW-1]} - {1'b0, dvs};
  assign quotient = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitudes go in, the sign is fixed up on the way out
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[DW-1] ? (~dividend + 1'b1) : dividend;
      dvs <= divisor[DW-1] ? (~divisor + 1'b1) : divisor;
      rem <= '0;
      neg <= dividend[DW-1] ^ divisor[DW-1];
    end else if (busy) begin
      if (!trial[DW]) begin
        rem <= trial[DW-1:0];
      end else begin
        rem <= {rem[DW-2:0], quo[DW-1]};
      end
      quo <= {quo[DW-2:0], ~trial[DW]};
    end
  end

endmodule

>>> src/srsu_dpath.sv
// datapath: configuration, request capture, element memory, alu, divider, output register
`timescale 1ns / 1ps

module srsu_dpath #(
  parameter int MAX_ROWS  = srsu_pkg::DEF_MAX_ROWS,
  parameter int MAX_WIDTH = srsu_pkg::DEF_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  srsu_pkg::ctrl_cmd_t        cmd,
  output srsu_pkg::dp_sts_t          sts,
  input  logic [1:0]                 kind,
  input  logic [7:0]                 row_index,
  input  logic [5:0]                 column_index,
  input  logic [srsu_pkg::DW-1:0]    operand_value,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [8:0]                 cfg_data,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [srsu_pkg::OUT_W-1:0] m_tdata
);
  import srsu_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_WIDTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [2:0] scatter_operation;
  logic [6:0] row_width;
  logic [8:0] table_height;

  // captured request
  logic [1:0]        kind_q;
  logic [DW-1:0]     opv_q;
  logic [ADDR_W-1:0] addr_q;
  logic              in_range_q;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data;

  logic [DW-1:0]   res_q;
  logic [1:0]      status_q;
  logic [DW-1:0]   res_next;
  logic [1:0]      status_next;
  logic [DW-1:0]   prod;
  logic [31:0]     addr_full;
  logic            row_ok;
  logic            col_ok;
  logic            div_done;
  logic [DW-1:0]   quotient;
  logic [DW-1:0]   div_a;
  logic [DW-1:0]   div_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      scatter_operation <= RST_OP;
      row_width         <= RST_WIDTH;
      table_height      <= RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OP:     scatter_operation <= cfg_data[2:0];
        CFG_WIDTH:  row_width         <= cfg_data[6:0];
        CFG_HEIGHT: table_height      <= cfg_data;
        default:    ;
      endcase
    end
  end

  // range check against both the configured and the built geometry
  assign row_ok = ({1'b0, row_index} < table_height) && (32'(row_index) < 32'(MAX_ROWS));
  assign col_ok = ({1'b0, column_index} < row_width) && (32'(column_index) < 32'(MAX_WIDTH));
  assign addr_full = 32'(row_index) * 32'(MAX_WIDTH) + 32'(column_index);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q     <= kind;
      opv_q      <= operand_value;
      addr_q     <= addr_full[ADDR_W-1:0];
      in_range_q <= row_ok && col_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && in_range_q) begin
      mem[addr_q] <= res_q;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[addr_q];
    end
  end

  // only the low word of the product is kept
  assign prod = rd_data * opv_q;

  always_comb begin
    res_next    = rd_data;
    status_next = STS_OK;
    if (!in_range_q) begin
      res_next    = '0;
      status_next = STS_RANGE;
    end else begin
      case (kind_q)
        KIND_LOAD: res_next = opv_q;
        KIND_APPLY: begin
          case (scatter_operation)
            OP_ASSIGN: res_next = opv_q;
            OP_ADD:    res_next = rd_data + opv_q;
            OP_SUB:    res_next = rd_data - opv_q;
            OP_RSUB:   res_next = opv_q - rd_data;
            OP_MUL:    res_next = prod;
            OP_DIV:    if (opv_q == '0) status_next = STS_DIVZ;
            OP_RDIV:   if (rd_data == '0) status_next = STS_DIVZ;
            default:   ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign sts.need_div = in_range_q && (kind_q == KIND_APPLY) &&
                        (((scatter_operation == OP_DIV) && (opv_q != '0)) ||
                         ((scatter_operation == OP_RDIV) && (rd_data != '0)));
  assign sts.div_done = div_done;
  assign sts.out_free = !m_tvalid || m_tready;

  assign div_a = (scatter_operation == OP_DIV) ? rd_data : opv_q;
  assign div_b = (scatter_operation == OP_DIV) ? opv_q : rd_data;

  srsu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_q    <= res_next;
      status_q <= status_next;
    end else if (cmd.div_load) begin
      res_q    <= quotient;
      status_q <= STS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {{(OUT_W - DW - 2){1'b0}}, status_q, res_q};
    end
  end

endmodule

>>> src/srsu_ctrl.sv
// controller state machine sequencing read, compute, divide and write-back
`timescale 1ns / 1ps

module srsu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output srsu_pkg::ctrl_cmd_t cmd,
  input  srsu_pkg::dp_sts_t   sts
);
  import srsu_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_READ;
      ST_READ:  state_next = ST_EXEC;
      ST_EXEC:  state_next = sts.need_div ? ST_DIV : ST_WRITE;
      ST_DIV:   if (sts.div_done) state_next = ST_WRITE;
      ST_WRITE: if (sts.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready      = (state == ST_IDLE);
    cmd.capture   = (state == ST_IDLE) && s_tvalid;
    cmd.mem_rd    = (state == ST_READ);
    cmd.exec      = (state == ST_EXEC) && !sts.need_div;
    cmd.div_start = (state == ST_EXEC) && sts.need_div;
    cmd.div_load  = (state == ST_DIV) && sts.div_done;
    cmd.commit    = (state == ST_WRITE) && sts.out_free;
  end

`ifndef SYNTHESIS
  a_capture_reads: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_READ))
    else $error("request capture not followed by memory read");

  a_div_to_write: assert property (@(posedge clk) disable iff (rst)
    cmd.div_load |=> (state == ST_WRITE))
    else $error("divider result not followed by write-back");

  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == ST_IDLE) && s_tready)
    else $error("commit did not return to idle");

  a_hold_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) && !sts.out_free |=> (state == ST_WRITE))
    else $error("write-back left while output register busy");
`endif

endmodule

>>> src/sparse_row_scatter_update_unit.sv
// Sparse row scatter update unit. One request names a table element by
// row and column: load it, apply the configured scatter operation
// (assign, add, sub, reverse sub, mul, div, reverse div) or read it back.
// Every request returns one result: the element after the request (zero
// if out of range) and a status (ok, row/column out of range, divide by
// zero). Requests come in on s_t*, results leave on m_t*; configuration
// uses cfg_we/cfg_index/cfg_data and is to be written only while the
// unit is idle; this is not enforced. One request is worked at a time.
// A non-divide request runs capture, memory read, compute and write-back
// before the next is accepted; the result is valid the cycle after
// write-back. Divide requests also use the bit-serial divider.
// The result sits in an output register, so the next request is accepted
// while it waits; write-back of a following result holds until that
// register is taken. Reset clears the controller, the output valid and
// the configuration (op add, row width 64, height 256); the element
// memory is not cleared and must be loaded before it is read.
`timescale 1ns / 1ps

module sparse_row_scatter_update_unit #(
  parameter int MAX_ROWS  = srsu_pkg::DEF_MAX_ROWS,
  parameter int MAX_WIDTH = srsu_pkg::DEF_MAX_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // row_index[7:0], column_index[13:8], operand_value[45:14], zero pad
  input  logic [srsu_pkg::IN_W-1:0]  s_tdata,
  // kind[1:0]
  input  logic [1:0]                 s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // element_value[31:0], status[33:32], zero pad
  output logic [srsu_pkg::OUT_W-1:0] m_tdata,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [8:0]                 cfg_data
);
  import srsu_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  srsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  srsu_dpath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (s_tuser),
    .row_index     (s_tdata[7:0]),
    .column_index  (s_tdata[13:8]),
    .operand_value (s_tdata[45:14]),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata)
  );

endmodule
